// File: rtl/core/sorted_list_insert_defines.svh
// ----------------------------------------------------------------------------
// sorted_list_insert_defines : assertion macros
// Shared concurrent assertion wrappers for the sorted list blocks.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DEFINES_SVH
`define SORTED_LIST_INSERT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_list_insert: assertion failed");

// Next-cycle implication, disabled while in reset.
`define SLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_list_insert: assertion failed");

`endif

// File: rtl/core/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg : sorted list insert package
// Sizes, state encoding and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 10;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int ID_W     = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_OVF
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic insert;
        logic emit_clear;
        logic emit_step;
        logic ovf_sel;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic last_entry;
    } status_t;

endpackage

// File: rtl/core/sli_if.sv
// ----------------------------------------------------------------------------
// sli_if : stream channels
// Input and output valid/ready channels of the sorted list block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sli_in_if;
    import sli_pkg::*;

    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sli_out_if;
    import sli_pkg::*;

    logic                valid;
    logic                ready;
    logic [3:0]          position;
    logic [4:0]          entry_id;
    logic [KEY_BITS-1:0] entry_value;
    logic                is_new;
    logic                overflow;
    logic                last;

    modport source (output valid, output position, output entry_id, output entry_value,
                    output is_new, output overflow, output last, input ready);
    modport sink   (input valid, input position, input entry_id, input entry_value,
                    input is_new, input overflow, input last, output ready);
endinterface

// File: rtl/core/sorted_list_insert.sv
// An accepted value is inserted at its accept edge; the first result is offered
//   in the following cycle and the rest follow one per cycle unless stalled.
// A new value is taken only once the readout of the previous list, or its
//   overflow report, is complete.
// Readout of the stored list, one entry per cycle unless stalled, sets the rate.
// Reset (rst_n, async, active low): list empty, identifier counter at one.
// ----------------------------------------------------------------------------
// sorted_list_insert : ascending sorted list with full readout
// Inserts each key ahead of the first entry greater or equal and then streams
// the complete list, smallest first, marking the new entry (overflow if full).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_insert (
    input  logic       clk,
    input  logic       rst_n,
    sli_in_if.sink     in_ch,
    sli_out_if.source  out_ch
);
    import sli_pkg::*;

    // Controller and datapath talk only through cmd and status.
    cmd_t    cmd;
    status_t status;

    // The controller takes one input transaction at a time: ready is high only
    // while no readout is pending. The insert itself is a parallel compare
    // across all stored entries, shifting those greater or equal up by one.
    sli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Output fields are driven straight from the stored list through the read
    // index, so they hold steady while the output transaction is stalled. On a
    // full list the single overflow transaction carries zeroed entry fields.
    sli_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_value    (in_ch.value),
        .position    (out_ch.position),
        .entry_id    (out_ch.entry_id),
        .entry_value (out_ch.entry_value),
        .is_new      (out_ch.is_new),
        .overflow    (out_ch.overflow),
        .last        (out_ch.last)
    );

endmodule

// File: rtl/core/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl : sorted list controller
// Sequences insert, list readout and overflow reporting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sli_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sli_pkg::status_t status,
    output sli_pkg::cmd_t    cmd
);
    import sli_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.full ? ST_OVF : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready && status.last_entry)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OVF:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd.insert     = 1'b0;
        cmd.emit_clear = 1'b0;
        cmd.emit_step  = 1'b0;
        cmd.ovf_sel    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.insert     = in_valid && !status.full;
                cmd.emit_clear = in_valid;
            end
            ST_EMIT:
            begin
                out_valid     = 1'b1;
                cmd.emit_step = out_ready && !status.last_entry;
            end
            ST_OVF:
            begin
                out_valid   = 1'b1;
                cmd.ovf_sel = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/sli_datapath.sv
// ----------------------------------------------------------------------------
// sli_datapath : sorted list storage and readout
// Parallel-compare insertion into a register list, indexed readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_list_insert_defines.svh"

module sli_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sli_pkg::cmd_t                cmd,
    output sli_pkg::status_t             status,
    input  logic [sli_pkg::KEY_BITS-1:0] in_value,
    output logic [3:0]                   position,
    output logic [4:0]                   entry_id,
    output logic [sli_pkg::KEY_BITS-1:0] entry_value,
    output logic                         is_new,
    output logic                         overflow,
    output logic                         last
);
    import sli_pkg::*;

    logic [KEY_BITS-1:0] key_reg [CAPACITY];
    logic [ID_W-1:0]     id_reg  [CAPACITY];
    logic [COUNT_W-1:0]  count_reg;
    logic [ID_W-1:0]     next_id_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    slot_next;

    logic [CAPACITY-1:0] gt;        // new key lies above stored entry
    logic [CAPACITY-1:0] ins_here;  // one-hot insert slot
    logic [CAPACITY-1:0] shift_up;  // take the entry below

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = (COUNT_W'(i) < count_reg) && (in_value > key_reg[i]);
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
            begin
                ins_here[i] = !gt[i];
                shift_up[i] = 1'b0;
            end
            else
            begin
                ins_here[i] = !gt[i] && gt[i-1];
                shift_up[i] = !gt[i-1];
            end
        end
        slot_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ins_here[i])
            begin
                slot_next = slot_next | IDX_W'(i);
            end
        end
    end

    // list storage, no reset: entries at or above the count are never read
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (ins_here[i])
                begin
                    key_reg[i] <= in_value;
                    id_reg[i]  <= next_id_reg;
                end
                else if (shift_up[i])
                begin
                    // entry 0 never shifts; the clamp keeps the index in range
                    key_reg[i] <= key_reg[(i > 0) ? i - 1 : 0];
                    id_reg[i]  <= id_reg[(i > 0) ? i - 1 : 0];
                end
            end
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_id_reg <= ID_W'(1);
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.insert)
            begin
                count_reg   <= count_reg + COUNT_W'(1);
                next_id_reg <= next_id_reg + ID_W'(1);
            end
            if (cmd.emit_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    assign status.full       = (count_reg >= COUNT_W'(CAPACITY));
    assign status.last_entry = ((COUNT_W'(idx_reg) + COUNT_W'(1)) == count_reg);

    assign position    = cmd.ovf_sel ? 4'd0 : 4'(idx_reg);
    assign entry_id    = cmd.ovf_sel ? 5'd0 : 5'(id_reg[idx_reg]);
    assign entry_value = cmd.ovf_sel ? '0 : key_reg[idx_reg];
    assign is_new      = !cmd.ovf_sel && (idx_reg == slot_reg);
    assign overflow    = cmd.ovf_sel;
    assign last        = cmd.ovf_sel || status.last_entry;

    `SLI_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= COUNT_W'(CAPACITY))
    `SLI_ASSERT_NOW(a_slot_onehot, clk, rst_n, cmd.insert, $onehot(ins_here))
    `SLI_ASSERT_NXT(a_count_inc, clk, rst_n, cmd.insert, count_reg == $past(count_reg) + COUNT_W'(1))

endmodule
